@@ sv/ede_pkg.sv @@
// Package for the edit distance engine: command codes, field widths,
// the token that travels along the cell chain and a saturating increment.
// No dependencies.
package ede_pkg;

  localparam int SYM_W           = 21;
  localparam int DIST_W          = 16;
  localparam int MAX_PATTERN_DEF = 64;

  localparam logic [1:0] CMD_PATTERN = 2'd0;
  localparam logic [1:0] CMD_TEXT    = 2'd1;
  localparam logic [1:0] CMD_FINISH  = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // One wavefront token: a text step or a finish sweep.
  typedef struct packed {
    logic              vld;
    logic              fin;
    logic              sub_mode;
    logic [SYM_W-1:0]  sym;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] diag;
  } token_t;

  // Adds zero or one and holds at the top of the range.
  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] x,
                                                input logic d);
    logic [DIST_W-1:0] r;
    if (x == DIST_MAX) begin
      r = x;
    end else begin
      r = x + {{(DIST_W-1){1'b0}}, d};
    end
    return r;
  endfunction

endpackage

@@ sv/ede_cell.sv @@
// One column cell of the edit distance chain: holds one pattern character and
// one row value, and updates that value as a token passes. Uses ede_pkg.
module ede_cell #(
  parameter int MAX_PATTERN = ede_pkg::MAX_PATTERN_DEF,
  parameter int IDX         = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ede_pkg::token_t                    tin,
  output ede_pkg::token_t                    tout,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]   len,
  input  logic                               pat_we,
  input  logic [ede_pkg::SYM_W-1:0]          pat_sym
);
  import ede_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] IDX_L  = LEN_W'(IDX);
  localparam logic [LEN_W-1:0] IDX_M1 = LEN_W'(IDX - 1);
  localparam logic [DIST_W-1:0] IDX_D = DIST_W'(IDX);

  logic [SYM_W-1:0]  pat_r;
  logic [DIST_W-1:0] row_r, row_nxt;
  token_t            tok_r, tok_nxt;

  logic              active, last;
  logic [DIST_W-1:0] c_left, c_up, c_diag, best;

  // Candidates from the left, from above and from the diagonal.
  always_comb begin
    last   = (IDX_L == len);
    active = tin.vld && !tin.fin && (IDX_L <= len);
    c_left = sat_inc(tin.left, 1'b1);
    c_up   = sat_inc(row_r, ~(tin.sub_mode & last));
    c_diag = sat_inc(tin.diag, pat_r != tin.sym);
    best   = c_left;
    if (c_up < best) begin
      best = c_up;
    end
    if (c_diag < best) begin
      best = c_diag;
    end
  end

  // A text token takes the new value on; a finish token picks up the
  // distance at the last pattern column and returns the row to its start.
  always_comb begin
    tok_nxt = tin;
    row_nxt = row_r;
    if (tin.vld && tin.fin) begin
      row_nxt = IDX_D;
      if (last) begin
        tok_nxt.left = row_r;
      end
    end else if (active) begin
      row_nxt      = best;
      tok_nxt.left = best;
      tok_nxt.diag = row_r;
    end
  end

  // Row value and token valid are control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= IDX_D;
      tok_r.vld <= 1'b0;
    end else begin
      row_r <= row_nxt;
      tok_r <= tok_nxt;
    end
  end

  // The pattern character is written while loading at this column.
  always_ff @(posedge clk) begin
    if (pat_we && (len == IDX_M1)) begin
      pat_r <= pat_sym;
    end
  end

  assign tout = tok_r;

endmodule

@@ sv/edit_distance_engine.sv @@
// Edit distance engine: Levenshtein distance of a pattern against a text,
// full or best-substring form, computed by a chain of MAX_PATTERN cells.
// Pattern and text requests are taken one per cycle while input is not
// stalled; text steps pipeline down the chain as a wavefront. A finish
// request sweeps the chain; input is stalled until its result is moved
// to the output register. Reset is synchronous: mode full, empty pattern,
// row values equal to their column index.
module edit_distance_engine #(
  parameter int MAX_PATTERN = ede_pkg::MAX_PATTERN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [ede_pkg::SYM_W-1:0]     in_symbol,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ede_pkg::DIST_W-1:0]    out_distance,
  output logic                          out_pattern_overflow,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_substring_mode
);
  import ede_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_PATTERN);

  logic              mode_r;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [DIST_W-1:0] tcnt_r, tcnt_nxt;
  logic [DIST_W-1:0] row0_r, row0_nxt;
  logic              ovf_r, ovf_nxt;
  logic              busy_r, busy_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [DIST_W-1:0] pend_dist_r;
  logic              pend_ovf_r;
  logic              out_vld_r, out_vld_nxt;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_ovf_r;
  token_t            ent_r, ent_nxt;
  logic              pat_we;
  logic              in_acc, fin_done, pend_move;
  token_t            chain [MAX_PATTERN+1];

  assign in_stall  = busy_r | pend_vld_r;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign chain[0]  = ent_r;
  assign fin_done  = chain[MAX_PATTERN].vld && chain[MAX_PATTERN].fin;
  assign pend_move = pend_vld_r && (!out_vld_r || !out_stall);

  // Request decode: pattern load, text step entry and finish entry.
  always_comb begin
    len_nxt      = len_r;
    tcnt_nxt     = tcnt_r;
    row0_nxt     = row0_r;
    ovf_nxt      = ovf_r;
    busy_nxt     = busy_r;
    pat_we       = 1'b0;
    ent_nxt      = ent_r;
    ent_nxt.vld  = 1'b0;
    if (in_acc) begin
      case (in_command)
        CMD_PATTERN: begin
          if (tcnt_r == '0) begin
            if (len_r == LEN_FULL) begin
              ovf_nxt = 1'b1;
            end else begin
              pat_we  = 1'b1;
              len_nxt = len_r + 1'b1;
            end
          end
        end
        CMD_TEXT: begin
          tcnt_nxt         = sat_inc(tcnt_r, 1'b1);
          ent_nxt.vld      = 1'b1;
          ent_nxt.fin      = 1'b0;
          ent_nxt.sub_mode = mode_r;
          ent_nxt.sym      = in_symbol;
          ent_nxt.left     = mode_r ? '0 : tcnt_nxt;
          ent_nxt.diag     = row0_r;
          row0_nxt         = ent_nxt.left;
        end
        CMD_FINISH: begin
          ent_nxt.vld      = 1'b1;
          ent_nxt.fin      = 1'b1;
          ent_nxt.sub_mode = mode_r;
          ent_nxt.sym      = in_symbol;
          ent_nxt.left     = row0_r;
          ent_nxt.diag     = row0_r;
          row0_nxt         = '0;
          busy_nxt         = 1'b1;
        end
        default: begin
        end
      endcase
    end
    // The sweep has left the chain: busy, pattern length, text count and overflow are cleared.
    if (fin_done) begin
      busy_nxt = 1'b0;
      len_nxt  = '0;
      tcnt_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  // Result staging and the output register.
  always_comb begin
    pend_vld_nxt = pend_vld_r;
    out_vld_nxt  = out_vld_r;
    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
    if (pend_move) begin
      out_vld_nxt  = 1'b1;
      pend_vld_nxt = 1'b0;
    end
    if (fin_done) begin
      pend_vld_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      len_r      <= '0;
      tcnt_r     <= '0;
      row0_r     <= '0;
      ovf_r      <= 1'b0;
      busy_r     <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      ent_r.vld  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_substring_mode;
      end
      len_r      <= len_nxt;
      tcnt_r     <= tcnt_nxt;
      row0_r     <= row0_nxt;
      ovf_r      <= ovf_nxt;
      busy_r     <= busy_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      ent_r      <= ent_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (fin_done) begin
      pend_dist_r <= chain[MAX_PATTERN].left;
      pend_ovf_r  <= ovf_r;
    end
    if (pend_move) begin
      out_dist_r <= pend_dist_r;
      out_ovf_r  <= pend_ovf_r;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_distance         = out_dist_r;
  assign out_pattern_overflow = out_ovf_r;

  // The row of pattern column cells.
  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    ede_cell #(
      .MAX_PATTERN(MAX_PATTERN),
      .IDX        (j)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tin    (chain[j-1]),
      .tout   (chain[j]),
      .len    (len_r),
      .pat_we (pat_we),
      .pat_sym(in_symbol)
    );
  end

  // A waiting result and a sweep in flight never coexist.
  a_pend_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_vld_r && busy_r))
    else $error("result pending while a finish sweep is in flight");

  // Accepting a finish request starts a sweep.
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_command == CMD_FINISH) |=> busy_r)
    else $error("finish accepted without starting a sweep");

  // A finish token only leaves the chain while a sweep is open.
  a_fin_tail: assert property (@(posedge clk) disable iff (!rst_n)
    fin_done |-> busy_r)
    else $error("finish token left the chain with no sweep open");

  // Each pattern write extends the stored pattern by one.
  a_pat_len: assert property (@(posedge clk) disable iff (!rst_n)
    pat_we |=> (len_r == $past(len_r) + 1'b1))
    else $error("pattern length did not advance on a pattern write");

endmodule
